>>> design/evi_pkg.sv
// Shared widths, codes and types of the eased value interpolator.
package evi_pkg;

   // Defaults for the top-level parameters
   localparam int FRAC_BITS_DEF  = 16;
   localparam int SINE_DEPTH_DEF = 256;

   // Field widths
   localparam int VALUE_W     = 32;
   localparam int DELTA_W     = 24;
   localparam int SPEED_W     = 32;
   localparam int MODE_W      = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_W       = ((2 * VALUE_W + DELTA_W + 7) / 8) * 8;

   // Sine samples are Q1.30
   localparam int SINE_W = 31;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Q1.30 constants
   localparam logic [MUL_B_W-1:0] FOUR_OVER_PI_Q30 = 32'd1367130551;
   localparam logic [MUL_B_W-1:0] INV_SIN2_Q30     = 32'd1180847948;
   localparam logic [63:0]        HALF_PI_Q30      = 64'd1686629713;

   // Request kinds
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Curve modes
   localparam logic [MODE_W-1:0] MODE_SIN2   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CUBIC  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QSINE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LINEAR = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_RATE = 1'b1;

   // Post-multiply shift selection
   typedef enum logic [2:0] {
      SH_NONE,
      SH_FRAC,
      SH_Q30,
      SH_SCALE,
      SH_TRIM
   } evi_shift_type;

   // One operation for the shared multiplier
   typedef struct packed {
      logic                       issue;
      logic                       round;
      evi_shift_type              shift;
      logic signed [MUL_A_W-1:0]  a;
      logic signed [MUL_B_W-1:0]  b;
   } evi_mul_op_type;

endpackage

>>> design/evi_mul_unit.sv
// Shared two-stage multiply, round and shift unit.
module evi_mul_unit #(
   parameter int FRAC_BITS = evi_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  evi_pkg::evi_mul_op_type             mul_op,
   output logic                                mul_done,
   output logic signed [evi_pkg::MUL_P_W-1:0]  mul_res
);

   localparam int PW = evi_pkg::MUL_P_W;
   localparam int SH_F     = FRAC_BITS;
   localparam int SH_Q     = 30;
   localparam int SH_SCL   = 60 - FRAC_BITS;
   localparam int SH_TRM   = 30 - FRAC_BITS;
   localparam logic signed [PW-1:0] HALF_F   = PW'(1) << (SH_F - 1);
   localparam logic signed [PW-1:0] HALF_Q   = PW'(1) << (SH_Q - 1);
   localparam logic signed [PW-1:0] HALF_SCL = PW'(1) << (SH_SCL - 1);
   localparam logic signed [PW-1:0] HALF_TRM = PW'(1) << (SH_TRM - 1);

   logic signed [PW-1:0]   prod_ff, prod_in;
   evi_pkg::evi_shift_type shift_ff;
   logic                   round_ff;
   logic                   valid_ff;
   logic                   done_ff;
   logic signed [PW-1:0]   res_ff, res_in;

   // Form the product
   always_comb begin
      prod_in = mul_op.a * mul_op.b;
   end

   // Round and scale the registered product
   always_comb begin
      case (shift_ff)
         evi_pkg::SH_NONE:  res_in = prod_ff;
         evi_pkg::SH_FRAC:  res_in = (prod_ff + (round_ff ? HALF_F : '0)) >>> SH_F;
         evi_pkg::SH_Q30:   res_in = (prod_ff + (round_ff ? HALF_Q : '0)) >>> SH_Q;
         evi_pkg::SH_SCALE: res_in = (prod_ff + (round_ff ? HALF_SCL : '0)) >>> SH_SCL;
         evi_pkg::SH_TRIM:  res_in = (prod_ff + (round_ff ? HALF_TRM : '0)) >>> SH_TRM;
         default:           res_in = prod_ff;
      endcase
   end

   // Track the operation through both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= mul_op.issue;
         done_ff  <= valid_ff;
      end
   end

   // Hold the data path
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      shift_ff <= mul_op.shift;
      round_ff <= mul_op.round;
      res_ff   <= res_in;
   end

   assign mul_done = done_ff;
   assign mul_res  = res_ff;

endmodule

>>> design/evi_sine_table.sv
// Quarter-wave sine table in Q1.30 with a registered read.
module evi_sine_table #(
   parameter int SINE_TABLE_DEPTH = evi_pkg::SINE_DEPTH_DEF
) (
   input  logic                                       clock,
   input  logic [$clog2(SINE_TABLE_DEPTH + 1)-1:0]    addr,
   output logic [evi_pkg::SINE_W-1:0]                 data
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;

   // Series sine of a Q1.30 angle in the first quadrant
   function automatic logic [63:0] taylor_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
         term = (term * x2) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = (sum > term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      return (sum > UNIT_Q30) ? UNIT_Q30 : sum;
   endfunction

   logic [evi_pkg::SINE_W-1:0] rom [0:SINE_TABLE_DEPTH];
   logic [evi_pkg::SINE_W-1:0] data_ff, data_in;

   // Build the samples at elaboration
   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] ANGLE = evi_pkg::HALF_PI_Q30 * k / SINE_TABLE_DEPTH;
      localparam logic [63:0] ENTRY = taylor_sine(ANGLE);
      assign rom[k] = ENTRY[evi_pkg::SINE_W-1:0];
   end

   // Select the sample, clamping past the last point
   always_comb begin
      if (addr > IDX_W'(SINE_TABLE_DEPTH)) begin
         data_in = rom[SINE_TABLE_DEPTH];
      end else begin
         data_in = rom[addr];
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> design/eased_value_interpolator.sv
// Top level of the eased value interpolator (tween engine).
// Requests arrive on req_*: tuser selects start (0) or tick (1). A start loads
// a start value and a target; a tick advances progress by tick_delta times
// speed_rate and moves the value along the curve set by curve_mode.
// Every request gives exactly one response on rsp_* with the present value,
// a busy flag and the progress in Q1.F.
// req_tready is high only while the sequencer is idle; one request is worked
// on at a time. A start, an idle tick or a final snap goes straight to the done
// state, which loads the response register once it is free. A moving tick runs
// through one shared two-stage multiplier: a step and a blend product for the
// linear curve, plus one squaring product for square and two for cubic; the sine
// modes add a position product, two table reads, a difference step and an
// interpolation and a scale product, sin2 a phase product first. The sequencer
// loads the response as it returns to idle, where alone it takes a request.
// Reset clears the tween state, sets curve_mode to 0 and speed_rate to 1.0.
// The response sits in an output register; the next request is accepted while
// it waits, and a finished response waits only if the previous one is still
// stalled by rsp_tready.
// Registers are written through csr_*; the user must do so only while the block
// is idle, which the block itself does not enforce.
module eased_value_interpolator #(
   parameter int SINE_TABLE_DEPTH = evi_pkg::SINE_DEPTH_DEF,
   parameter int FRAC_BITS        = evi_pkg::FRAC_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // start_value, target_value, tick_delta
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [evi_pkg::REQ_W-1:0]                  req_tdata,
   // opcode
   input  logic                                       req_tuser,
   // value_out, busy_res, progress, zero fill
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [((evi_pkg::VALUE_W + FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                       csr_we,
   input  logic [evi_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  logic [evi_pkg::CSR_DATA_W-1:0]             csr_wdata
);

   localparam int VW      = evi_pkg::VALUE_W;
   localparam int PROG_W  = FRAC_BITS + 1;
   localparam int CURVE_W = FRAC_BITS + 2;
   localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int RSP_W   = ((VW + FRAC_BITS + 2 + 7) / 8) * 8;
   localparam int BLEND_W = VW + 4;
   localparam int SW      = evi_pkg::SINE_W;
   localparam int AW      = evi_pkg::MUL_A_W;
   localparam int BW      = evi_pkg::MUL_B_W;
   localparam int PW      = evi_pkg::MUL_P_W;

   localparam logic [PROG_W-1:0]  ONE     = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CURVE_W-1:0] ONE_C   = {2'b01, {FRAC_BITS{1'b0}}};
   localparam logic [CURVE_W-1:0] TWO_C   = {2'b10, {FRAC_BITS{1'b0}}};
   localparam logic signed [PW-1:0] ONE_P = {{(PW - PROG_W){1'b0}}, ONE};
   localparam logic [evi_pkg::SPEED_W-1:0] SPEED_RESET =
      {{(evi_pkg::SPEED_W - PROG_W){1'b0}}, ONE};
   localparam logic signed [BLEND_W-1:0] VMAX =
      {{(BLEND_W - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
   localparam logic signed [BLEND_W-1:0] VMIN =
      {{(BLEND_W - VW + 1){1'b1}}, {(VW - 1){1'b0}}};

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_STEP_MUL,
      ST_STEP_WB,
      ST_DISPATCH,
      ST_U_MUL,
      ST_U_WB,
      ST_POS_MUL,
      ST_POS_WB,
      ST_LO_RD,
      ST_HI_RD,
      ST_DIFF,
      ST_INT_MUL,
      ST_INT_WB,
      ST_SCL_MUL,
      ST_SCL_WB,
      ST_SQ1_MUL,
      ST_SQ1_WB,
      ST_SQ2_MUL,
      ST_SQ2_WB,
      ST_BLD_MUL,
      ST_BLD_WB,
      ST_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [evi_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic [evi_pkg::SPEED_W-1:0]     speed_ff, speed_in;
   logic                            active_ff, active_in;
   logic [PROG_W-1:0]               progress_ff, progress_in;
   logic signed [VW-1:0]            origin_ff, origin_in;
   logic signed [VW:0]              span_ff, span_in;
   logic signed [VW-1:0]            goal_ff, goal_in;
   logic signed [VW-1:0]            present_ff, present_in;
   logic                            busy_ff, busy_in;
   logic [evi_pkg::DELTA_W-1:0]     delta_ff, delta_in;
   logic [PROG_W-1:0]               d_ff, d_in;
   logic [PROG_W-1:0]               d2_ff, d2_in;
   logic [PROG_W-1:0]               u_ff, u_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [FRAC_BITS-1:0]            fr_ff, fr_in;
   logic [SW-1:0]                   lo_ff, lo_in;
   logic [SW-1:0]                   diff_ff, diff_in;
   logic                            dir_ff, dir_in;
   logic [SW-1:0]                   sine_ff, sine_in;
   logic [CURVE_W-1:0]              curve_ff, curve_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]                rsp_data_ff, rsp_data_in;

   logic signed [VW-1:0]            req_start;
   logic signed [VW-1:0]            req_target;
   logic [evi_pkg::DELTA_W-1:0]     req_delta;
   logic                            req_take;

   evi_pkg::evi_mul_op_type         mul_op;
   logic                            mul_done;
   logic signed [PW-1:0]            mul_res;

   logic [IDX_W-1:0]                tbl_addr;
   logic [IDX_W-1:0]                hi_idx;
   logic [SW-1:0]                   tbl_data;

   logic [PROG_W:0]                 step_sum;
   logic [CURVE_W-1:0]              u_raw;
   logic signed [BLEND_W-1:0]       blend_sum;

   // Unpack the request
   assign req_start  = req_tdata[VW-1:0];
   assign req_target = req_tdata[2*VW-1:VW];
   assign req_delta  = req_tdata[2*VW +: evi_pkg::DELTA_W];
   assign req_take   = req_tvalid && req_tready;

   evi_mul_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_op   (mul_op),
      .mul_done (mul_done),
      .mul_res  (mul_res)
   );

   evi_sine_table #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine (
      .clock (clock),
      .addr  (tbl_addr),
      .data  (tbl_data)
   );

   // Address the table: low point, then the next point clamped at the end
   always_comb begin
      if (idx_ff >= IDX_W'(SINE_TABLE_DEPTH)) begin
         hi_idx = IDX_W'(SINE_TABLE_DEPTH);
      end else begin
         hi_idx = idx_ff + IDX_W'(1);
      end
      tbl_addr = (state_ff == ST_HI_RD) ? hi_idx : idx_ff;
   end

   // Issue multiplier operations from the sequencer
   always_comb begin
      mul_op       = '0;
      mul_op.shift = evi_pkg::SH_NONE;
      case (state_ff)
         ST_STEP_MUL: begin
            mul_op.issue = 1'b1;
            mul_op.a     = AW'(speed_ff);
            mul_op.b     = BW'(delta_ff);
            mul_op.shift = evi_pkg::SH_FRAC;
         end
         ST_U_MUL: begin
            mul_op.issue = 1'b1;
            mul_op.round = 1'b1;
            mul_op.a     = AW'(progress_ff);
            mul_op.b     = evi_pkg::FOUR_OVER_PI_Q30;
            mul_op.shift = evi_pkg::SH_Q30;
         end
         ST_POS_MUL: begin
            mul_op.issue = 1'b1;
            mul_op.a     = AW'(u_ff);
            mul_op.b     = BW'(SINE_TABLE_DEPTH);
            mul_op.shift = evi_pkg::SH_NONE;
         end
         ST_INT_MUL: begin
            mul_op.issue = 1'b1;
            mul_op.a     = AW'(diff_ff);
            mul_op.b     = BW'(fr_ff);
            mul_op.shift = evi_pkg::SH_FRAC;
         end
         ST_SCL_MUL: begin
            mul_op.issue = 1'b1;
            mul_op.round = 1'b1;
            mul_op.a     = AW'(sine_ff);
            if (mode_ff == evi_pkg::MODE_SIN2) begin
               mul_op.b     = evi_pkg::INV_SIN2_Q30;
               mul_op.shift = evi_pkg::SH_SCALE;
            end else begin
               mul_op.b     = BW'(1);
               mul_op.shift = evi_pkg::SH_TRIM;
            end
         end
         ST_SQ1_MUL: begin
            mul_op.issue = 1'b1;
            mul_op.round = 1'b1;
            mul_op.a     = AW'(d_ff);
            mul_op.b     = BW'(d_ff);
            mul_op.shift = evi_pkg::SH_FRAC;
         end
         ST_SQ2_MUL: begin
            mul_op.issue = 1'b1;
            mul_op.round = 1'b1;
            mul_op.a     = AW'(d2_ff);
            mul_op.b     = BW'(d_ff);
            mul_op.shift = evi_pkg::SH_FRAC;
         end
         ST_BLD_MUL: begin
            mul_op.issue = 1'b1;
            mul_op.round = 1'b1;
            mul_op.a     = AW'(span_ff);
            mul_op.b     = BW'(curve_ff);
            mul_op.shift = evi_pkg::SH_FRAC;
         end
         default: begin
            mul_op.issue = 1'b0;
         end
      endcase
   end

   // Next-state and data path of the sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      speed_in     = speed_ff;
      active_in    = active_ff;
      progress_in  = progress_ff;
      origin_in    = origin_ff;
      span_in      = span_ff;
      goal_in      = goal_ff;
      present_in   = present_ff;
      busy_in      = busy_ff;
      delta_in     = delta_ff;
      d_in         = d_ff;
      d2_in        = d2_ff;
      u_in         = u_ff;
      idx_in       = idx_ff;
      fr_in        = fr_ff;
      lo_in        = lo_ff;
      diff_in      = diff_ff;
      dir_in       = dir_ff;
      sine_in      = sine_ff;
      curve_in     = curve_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      step_sum     = {1'b0, progress_ff} + (PROG_W + 1)'(mul_res[PROG_W-1:0]);
      u_raw        = mul_res[CURVE_W-1:0];
      blend_sum    = BLEND_W'(origin_ff) + mul_res[BLEND_W-1:0];

      // Register writes
      if (csr_we) begin
         case (csr_index)
            evi_pkg::CSR_CURVE_MODE: mode_in  = csr_wdata[evi_pkg::MODE_W-1:0];
            evi_pkg::CSR_SPEED_RATE: speed_in = csr_wdata[evi_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_DONE;
               if (req_tuser == evi_pkg::OP_START) begin
                  busy_in = 1'b1;
                  if (!active_ff || req_target != goal_ff) begin
                     goal_in     = req_target;
                     origin_in   = req_start;
                     present_in  = req_start;
                     span_in     = {req_target[VW-1], req_target}
                                 - {req_start[VW-1], req_start};
                     progress_in = (req_start == req_target) ? ONE : '0;
                     active_in   = 1'b1;
                  end else if (present_ff == goal_ff) begin
                     progress_in = ONE;
                  end
               end else if (!active_ff) begin
                  busy_in = 1'b0;
               end else if (progress_ff < ONE) begin
                  delta_in = req_delta;
                  state_in = ST_STEP_MUL;
               end else if (present_ff != goal_ff) begin
                  present_in = goal_ff;
                  active_in  = 1'b0;
                  busy_in    = 1'b1;
               end else begin
                  active_in = 1'b0;
                  busy_in   = 1'b0;
               end
            end
         end
         ST_STEP_MUL: state_in = ST_STEP_WB;
         ST_STEP_WB: begin
            // Advance progress, saturate at one
            if (mul_done) begin
               if (mul_res > ONE_P || step_sum > {1'b0, ONE}) begin
                  progress_in = ONE;
               end else begin
                  progress_in = step_sum[PROG_W-1:0];
               end
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (mode_ff)
               evi_pkg::MODE_SIN2: state_in = ST_U_MUL;
               evi_pkg::MODE_SQUARE: begin
                  d_in     = progress_ff;
                  state_in = ST_SQ1_MUL;
               end
               evi_pkg::MODE_CUBIC: begin
                  d_in     = ONE - progress_ff;
                  state_in = ST_SQ1_MUL;
               end
               evi_pkg::MODE_QSINE: begin
                  u_in     = progress_ff;
                  state_in = ST_POS_MUL;
               end
               default: begin
                  curve_in = CURVE_W'(progress_ff);
                  state_in = ST_BLD_MUL;
               end
            endcase
         end
         ST_U_MUL: state_in = ST_U_WB;
         ST_U_WB: begin
            // Reflect the phase above a quarter turn
            if (mul_done) begin
               if (u_raw > ONE_C) begin
                  u_in = PROG_W'(TWO_C - u_raw);
               end else begin
                  u_in = u_raw[PROG_W-1:0];
               end
               state_in = ST_POS_MUL;
            end
         end
         ST_POS_MUL: state_in = ST_POS_WB;
         ST_POS_WB: begin
            if (mul_done) begin
               idx_in   = mul_res[FRAC_BITS +: IDX_W];
               fr_in    = mul_res[FRAC_BITS-1:0];
               state_in = ST_LO_RD;
            end
         end
         ST_LO_RD: state_in = ST_HI_RD;
         ST_HI_RD: begin
            lo_in    = tbl_data;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            if (tbl_data >= lo_ff) begin
               dir_in  = 1'b1;
               diff_in = tbl_data - lo_ff;
            end else begin
               dir_in  = 1'b0;
               diff_in = lo_ff - tbl_data;
            end
            state_in = ST_INT_MUL;
         end
         ST_INT_MUL: state_in = ST_INT_WB;
         ST_INT_WB: begin
            if (mul_done) begin
               sine_in  = dir_ff ? lo_ff + mul_res[SW-1:0] : lo_ff - mul_res[SW-1:0];
               state_in = ST_SCL_MUL;
            end
         end
         ST_SCL_MUL: state_in = ST_SCL_WB;
         ST_SCL_WB: begin
            if (mul_done) begin
               curve_in = mul_res[CURVE_W-1:0];
               state_in = ST_BLD_MUL;
            end
         end
         ST_SQ1_MUL: state_in = ST_SQ1_WB;
         ST_SQ1_WB: begin
            if (mul_done) begin
               if (mode_ff == evi_pkg::MODE_CUBIC) begin
                  d2_in    = mul_res[PROG_W-1:0];
                  state_in = ST_SQ2_MUL;
               end else begin
                  curve_in = mul_res[CURVE_W-1:0];
                  state_in = ST_BLD_MUL;
               end
            end
         end
         ST_SQ2_MUL: state_in = ST_SQ2_WB;
         ST_SQ2_WB: begin
            if (mul_done) begin
               curve_in = CURVE_W'(ONE - mul_res[PROG_W-1:0]);
               state_in = ST_BLD_MUL;
            end
         end
         ST_BLD_MUL: state_in = ST_BLD_WB;
         ST_BLD_WB: begin
            // Add the offset to the origin, clamp to the value range
            if (mul_done) begin
               if (blend_sum > VMAX) begin
                  present_in = VMAX[VW-1:0];
               end else if (blend_sum < VMIN) begin
                  present_in = VMIN[VW-1:0];
               end else begin
                  present_in = blend_sum[VW-1:0];
               end
               busy_in  = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the response over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({progress_ff, busy_ff, present_ff});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold sequencer state, tween state and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= evi_pkg::MODE_SIN2;
         speed_ff     <= SPEED_RESET;
         active_ff    <= 1'b0;
         progress_ff  <= '0;
         origin_ff    <= '0;
         span_ff      <= '0;
         goal_ff      <= '0;
         present_ff   <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         speed_ff     <= speed_in;
         active_ff    <= active_in;
         progress_ff  <= progress_in;
         origin_ff    <= origin_in;
         span_ff      <= span_in;
         goal_ff      <= goal_in;
         present_ff   <= present_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         delta_ff     <= delta_in;
         d_ff         <= d_in;
         d2_ff        <= d2_in;
         u_ff         <= u_in;
         idx_ff       <= idx_in;
         fr_ff        <= fr_in;
         lo_ff        <= lo_in;
         diff_ff      <= diff_in;
         dir_ff       <= dir_in;
         sine_ff      <= sine_in;
         curve_ff     <= curve_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Drop ready right after taking a request
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("ready stayed high after a request was taken");

   // A start always arms the tween
   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tuser == evi_pkg::OP_START) |=> active_ff)
      else $error("start request did not arm the tween");

   // A tick while idle leaves the value alone and reports not busy
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tuser == evi_pkg::OP_TICK && !active_ff)
      |=> ($stable(present_ff) && !busy_ff))
      else $error("idle tick changed the value or reported busy");

   // Multiplier results land only in a write-back state
   a_done_wb: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_STEP_WB || state_ff == ST_U_WB ||
                    state_ff == ST_POS_WB || state_ff == ST_INT_WB ||
                    state_ff == ST_SCL_WB || state_ff == ST_SQ1_WB ||
                    state_ff == ST_SQ2_WB || state_ff == ST_BLD_WB))
      else $error("multiplier result arrived outside a write-back state");

endmodule
